FILE: hw/rtl/agt_pkg.sv
package agt_pkg;

	// Input command codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_TRACE = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 8'd128;

	// Coordinate widths: ports are 8 bits, a walk position can reach 256.
	localparam int COORD_W = 8;
	localparam int POS_W   = 9;
	localparam int CODE_W  = 3;
	localparam int SIDE_W  = 3;

	localparam logic [CODE_W-1:0] DIR_UP    = 3'd1;
	localparam logic [CODE_W-1:0] DIR_RIGHT = 3'd2;
	localparam logic [CODE_W-1:0] DIR_DOWN  = 3'd3;
	localparam logic [CODE_W-1:0] DIR_LEFT  = 3'd4;

	localparam logic [SIDE_W-1:0] SIDE_SOUTH = 3'd0;
	localparam logic [SIDE_W-1:0] SIDE_NORTH = 3'd1;
	localparam logic [SIDE_W-1:0] SIDE_WEST  = 3'd2;
	localparam logic [SIDE_W-1:0] SIDE_EAST  = 3'd3;
	localparam logic [SIDE_W-1:0] SIDE_LOOP  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;       // clearing pass: zero one entry of both memories
		logic load;      // store one cell code
		logic init;      // capture the start cell of a trace
		logic rd;        // read both memories at the current position
		logic step;      // write the mark at the position and follow its arrow
		logic mark_val;  // value of the mark written by a step
		logic emit;      // capture the exit side and raise done for one cycle
		logic restart;   // return to the start cell for the unmarking walk
	} agt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;  // clearing pass is at its last entry
		logic in_grid;   // current position lies inside the configured grid
		logic vis;       // mark read at the current position
	} agt_status_t;

endpackage

FILE: hw/rtl/agt_ctrl.sv
module agt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 command,
	input  agt_pkg::agt_status_t st,
	output agt_pkg::agt_cmd_t    cmd,
	output logic                 busy
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_RD    = 4'b0100,
		S_EV    = 4'b1000
	} agt_state_t;

	agt_state_t state_q, state_nxt;
	logic first_q;
	logic undo_q;
	logic proceed;

	// The first cell of either walk is always taken; after that the marking walk
	// needs an unmarked cell and the unmarking walk needs a marked one.
	assign proceed = first_q || (st.in_grid && (st.vis == undo_q));
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (command == agt_pkg::CMD_TRACE) begin
						cmd.init = 1'b1;
						state_nxt = S_RD;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_nxt = S_EV;
			end
			S_EV: begin
				if (proceed) begin
					cmd.step = 1'b1;
					cmd.mark_val = !undo_q;
					state_nxt = S_RD;
				end else if (!undo_q) begin
					cmd.emit = 1'b1;
					cmd.restart = 1'b1;
					state_nxt = S_RD;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			first_q <= 1'b0;
			undo_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.init) begin
				first_q <= 1'b1;
				undo_q <= 1'b0;
			end else if (cmd.restart) begin
				first_q <= 1'b1;
				undo_q <= 1'b1;
			end else if (cmd.step) begin
				first_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/agt_datapath.sv
module agt_datapath #(
	parameter int MAX_DIM = 128
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [agt_pkg::CFG_IDX_W-1:0]          cfg_addr,
	input  logic [agt_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	input  logic [agt_pkg::COORD_W-1:0]            row,
	input  logic [agt_pkg::COORD_W-1:0]            col,
	input  logic [agt_pkg::CODE_W-1:0]             direction,
	input  agt_pkg::agt_cmd_t                      cmd,
	output agt_pkg::agt_status_t                   st,
	output logic                                   done,
	output logic [agt_pkg::SIDE_W-1:0]             exit_side
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int AW = 2 * CW;
	localparam int DEPTH = 1 << AW;

	logic [agt_pkg::CODE_W-1:0] grid_mem [DEPTH];
	logic                       vis_mem  [DEPTH];

	logic [agt_pkg::CFG_DATA_W-1:0] num_rows_q, num_cols_q;
	logic [agt_pkg::POS_W-1:0]      pos_r_q, pos_c_q;
	logic [agt_pkg::COORD_W-1:0]    start_r_q, start_c_q;
	logic [AW-1:0]                  clr_q;
	logic [agt_pkg::CODE_W-1:0]     code_rd_q;
	logic                           vis_rd_q;
	logic                           done_q;
	logic [agt_pkg::SIDE_W-1:0]     side_q;

	logic [31:0]                    pr_m1, pc_m1, lr_m1, lc_m1;
	logic [AW-1:0]                  pos_addr, load_addr;
	logic                           pos_in_store, load_in_store;
	logic [agt_pkg::POS_W-1:0]      rows_ext, cols_ext;
	logic [agt_pkg::CODE_W-1:0]     code_use;
	logic [agt_pkg::POS_W-1:0]      next_r, next_c;
	logic [agt_pkg::SIDE_W-1:0]     side;

	assign rows_ext = {1'b0, num_rows_q};
	assign cols_ext = {1'b0, num_cols_q};

	assign pos_in_store = (pos_r_q != '0) && (pos_c_q != '0) &&
		(32'(pos_r_q) <= MAX_DIM) && (32'(pos_c_q) <= MAX_DIM);
	assign load_in_store = (row != '0) && (col != '0) &&
		(32'(row) <= MAX_DIM) && (32'(col) <= MAX_DIM);

	// Row-major address with the column in the low bits.
	assign pr_m1 = 32'(pos_r_q) - 32'd1;
	assign pc_m1 = 32'(pos_c_q) - 32'd1;
	assign lr_m1 = 32'(row) - 32'd1;
	assign lc_m1 = 32'(col) - 32'd1;
	assign pos_addr  = {pr_m1[CW-1:0], pc_m1[CW-1:0]};
	assign load_addr = {lr_m1[CW-1:0], lc_m1[CW-1:0]};

	assign st.clr_last = &clr_q;
	assign st.in_grid = pos_in_store && (pos_r_q <= rows_ext) && (pos_c_q <= cols_ext);
	assign st.vis = vis_rd_q;

	// A position outside the storage has no code and points to the corner.
	assign code_use = pos_in_store ? code_rd_q : '0;

	always_comb begin
		next_r = pos_r_q;
		next_c = pos_c_q;
		case (code_use)
			agt_pkg::DIR_UP:    next_r = pos_r_q - 9'd1;
			agt_pkg::DIR_RIGHT: next_c = pos_c_q + 9'd1;
			agt_pkg::DIR_DOWN:  next_r = pos_r_q + 9'd1;
			agt_pkg::DIR_LEFT:  next_c = pos_c_q - 9'd1;
			default: begin
				next_r = '0;
				next_c = '0;
			end
		endcase
	end

	always_comb begin
		if ((pos_r_q > rows_ext) || (32'(pos_r_q) > MAX_DIM)) begin
			side = agt_pkg::SIDE_SOUTH;
		end else if (pos_r_q == '0) begin
			side = agt_pkg::SIDE_NORTH;
		end else if (pos_c_q == '0) begin
			side = agt_pkg::SIDE_WEST;
		end else if ((pos_c_q > cols_ext) || (32'(pos_c_q) > MAX_DIM)) begin
			side = agt_pkg::SIDE_EAST;
		end else begin
			side = agt_pkg::SIDE_LOOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= agt_pkg::DIM_RESET;
			num_cols_q <= agt_pkg::DIM_RESET;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					agt_pkg::REG_NUM_ROWS: num_rows_q <= cfg_wdata;
					agt_pkg::REG_NUM_COLS: num_cols_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			start_r_q <= row;
			start_c_q <= col;
			pos_r_q <= {1'b0, row};
			pos_c_q <= {1'b0, col};
		end else if (cmd.restart) begin
			pos_r_q <= {1'b0, start_r_q};
			pos_c_q <= {1'b0, start_c_q};
		end else if (cmd.step) begin
			pos_r_q <= next_r;
			pos_c_q <= next_c;
		end
		if (cmd.emit) begin
			side_q <= side;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			grid_mem[clr_q] <= '0;
		end else if (cmd.load && load_in_store) begin
			grid_mem[load_addr] <= direction;
		end
		if (cmd.rd) begin
			code_rd_q <= grid_mem[pos_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			vis_mem[clr_q] <= 1'b0;
		end else if (cmd.step && pos_in_store) begin
			vis_mem[pos_addr] <= cmd.mark_val;
		end
		if (cmd.rd) begin
			vis_rd_q <= vis_mem[pos_addr];
		end
	end

	assign done = done_q;
	assign exit_side = side_q;

endmodule

FILE: hw/rtl/arrow_grid_exit_tracer.sv
// A load is taken while busy stays low, so loads stream one per cycle while idle.
// A trace follows the arrows from its start cell, marking each cell, raises done
// with the exit side, then walks again from the start cell to clear the marks.
// Each step is a registered memory read (S_RD) followed by an evaluate (S_EV).
// After reset, busy stays high for a clearing pass over all 4**ceil(log2(MAX_DIM)) entries.
// The result is on exit_side for the single cycle done is high; it cannot stall.
module arrow_grid_exit_tracer #(
	parameter int MAX_DIM = 128
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   command,
	input  logic [agt_pkg::COORD_W-1:0]            row,
	input  logic [agt_pkg::COORD_W-1:0]            col,
	input  logic [agt_pkg::CODE_W-1:0]             direction,
	output logic                                   done,
	output logic [agt_pkg::SIDE_W-1:0]             exit_side,
	input  logic                                   cfg_wr_en,
	input  logic [agt_pkg::CFG_IDX_W-1:0]          cfg_addr,
	input  logic [agt_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

	agt_pkg::agt_cmd_t    cmd;
	agt_pkg::agt_status_t st;

	agt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.st      (st),
		.cmd     (cmd),
		.busy    (busy)
	);

	agt_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.row       (row),
		.col       (col),
		.direction (direction),
		.cmd       (cmd),
		.st        (st),
		.done      (done),
		.exit_side (exit_side)
	);

endmodule

FILE: hw/rtl/agt_checker.sv
module agt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        command,
	input logic                        done,
	input logic [agt_pkg::SIDE_W-1:0]  exit_side
);

	// A result only appears while the trace is still in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a trace");

	// Each trace gives a single result strobe.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// An accepted trace transaction makes the block busy.
	a_trace_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == agt_pkg::CMD_TRACE)) |=> busy)
		else $error("trace accepted but block not busy");

	// A load transaction never blocks the next one.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == agt_pkg::CMD_LOAD)) |=> !busy)
		else $error("load made the block busy");

	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (exit_side <= agt_pkg::SIDE_LOOP))
		else $error("exit side code out of range");

endmodule

bind arrow_grid_exit_tracer agt_checker u_agt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.command   (command),
	.done      (done),
	.exit_side (exit_side)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int GRID_MAX = 128;
	localparam int GRID_CELLS = GRID_MAX * GRID_MAX;
	localparam int ITEM_GOAL = 1150;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_LIMIT = 10;
	localparam logic [agt_pkg::CODE_W-1:0] DIR_NONE = 3'd0;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic command;
	logic [agt_pkg::COORD_W-1:0] row;
	logic [agt_pkg::COORD_W-1:0] col;
	logic [agt_pkg::CODE_W-1:0] direction;
	logic done;
	logic [agt_pkg::SIDE_W-1:0] exit_side;
	logic cfg_wr_en;
	logic [agt_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [agt_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// Shadow state of the grid and the configured dimensions.
	logic [agt_pkg::CODE_W-1:0] grid_code [0:GRID_CELLS-1];
	bit visit_mark [0:GRID_CELLS-1];
	logic [agt_pkg::CFG_DATA_W-1:0] rows_cfg = agt_pkg::DIM_RESET;
	logic [agt_pkg::CFG_DATA_W-1:0] cols_cfg = agt_pkg::DIM_RESET;

	logic [agt_pkg::SIDE_W-1:0] pending_exits [$];
	int fail_count = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit no_gaps = 1'b0;

	arrow_grid_exit_tracer #(
		.MAX_DIM(GRID_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.row(row),
		.col(col),
		.direction(direction),
		.done(done),
		.exit_side(exit_side),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		foreach (grid_code[i]) begin
			grid_code[i] = DIR_NONE;
			visit_mark[i] = 1'b0;
		end
	end

	always #4 clk = ~clk;

	function automatic bit in_store(input int r, input int c);
		return r >= 1 && r <= GRID_MAX && c >= 1 && c <= GRID_MAX;
	endfunction

	function automatic int cell_of(input int r, input int c);
		return (r - 1) * GRID_MAX + (c - 1);
	endfunction

	function automatic void follow_arrow(input int r, input int c, output int nr, output int nc);
		logic [agt_pkg::CODE_W-1:0] code;
		code = in_store(r, c) ? grid_code[cell_of(r, c)] : DIR_NONE;
		nr = 0;
		nc = 0;
		case (code)
			agt_pkg::DIR_UP: begin
				nr = r - 1;
				nc = c;
			end
			agt_pkg::DIR_RIGHT: begin
				nr = r;
				nc = c + 1;
			end
			agt_pkg::DIR_DOWN: begin
				nr = r + 1;
				nc = c;
			end
			agt_pkg::DIR_LEFT: begin
				nr = r;
				nc = c - 1;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [agt_pkg::SIDE_W-1:0] predict_exit(input int r, input int c);
		int n;
		int m;
		int pr;
		int pc;
		int nr;
		int nc;
		int marked [$];
		logic [agt_pkg::SIDE_W-1:0] side;
		n = (rows_cfg > GRID_MAX) ? GRID_MAX : rows_cfg;
		m = (cols_cfg > GRID_MAX) ? GRID_MAX : cols_cfg;
		if (in_store(r, c)) begin
			visit_mark[cell_of(r, c)] = 1'b1;
			marked.push_back(cell_of(r, c));
		end
		follow_arrow(r, c, pr, pc);
		while (pr >= 1 && pr <= n && pc >= 1 && pc <= m && !visit_mark[cell_of(pr, pc)]) begin
			visit_mark[cell_of(pr, pc)] = 1'b1;
			marked.push_back(cell_of(pr, pc));
			follow_arrow(pr, pc, nr, nc);
			pr = nr;
			pc = nc;
		end
		if (pr > n)
			side = agt_pkg::SIDE_SOUTH;
		else if (pr < 1)
			side = agt_pkg::SIDE_NORTH;
		else if (pc < 1)
			side = agt_pkg::SIDE_WEST;
		else if (pc > m)
			side = agt_pkg::SIDE_EAST;
		else
			side = agt_pkg::SIDE_LOOP;
		// Only the cells touched by this walk need their marks cleared.
		foreach (marked[i])
			visit_mark[marked[i]] = 1'b0;
		return side;
	endfunction

	task automatic note_error(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : check_results
		logic [agt_pkg::SIDE_W-1:0] want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					agt_pkg::REG_NUM_ROWS: rows_cfg = cfg_wdata;
					agt_pkg::REG_NUM_COLS: cols_cfg = cfg_wdata;
					default: ;
				endcase
			end
			if (done) begin
				if (pending_exits.size() == 0) begin
					note_error($sformatf("exit_side %0d with no trace outstanding", exit_side));
				end else begin
					want = pending_exits.pop_front();
					if (exit_side !== want)
						note_error($sformatf("exit_side expected %0d, got %0d", want, exit_side));
				end
			end
			if (start && !busy) begin
				if (command == agt_pkg::CMD_LOAD) begin
					if (in_store(row, col))
						grid_code[cell_of(row, col)] = direction;
				end else begin
					pending_exits.push_back(predict_exit(row, col));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Returns with start still high when no gap follows, so the caller must
	// either issue the next transaction or call wait_idle in the same step.
	task automatic issue_command(input logic cmd, input int r, input int c, input int d);
		int gap;
		int sel;
		start <= 1'b1;
		command <= cmd;
		row <= agt_pkg::COORD_W'(r);
		col <= agt_pkg::COORD_W'(c);
		direction <= agt_pkg::CODE_W'(d);
		do
			@(posedge clk);
		while (busy !== 1'b0);
		items_sent++;
		gap = 0;
		if (!no_gaps) begin
			sel = $urandom_range(0, 99);
			if (sel >= 98)
				gap = $urandom_range(20, 60);
			else if (sel >= 90)
				gap = $urandom_range(4, 12);
			else if (sel >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_exits.size() != 0 || busy !== 1'b0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input int rows_val, input int cols_val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= agt_pkg::REG_NUM_ROWS;
		cfg_wdata <= agt_pkg::CFG_DATA_W'(rows_val);
		@(posedge clk);
		cfg_addr <= agt_pkg::REG_NUM_COLS;
		cfg_wdata <= agt_pkg::CFG_DATA_W'(cols_val);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int pick_dim();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 0;
			1: return GRID_MAX;
			2: return $urandom_range(GRID_MAX + 1, 255);
			3: return 1;
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	function automatic int random_code();
		int v;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(agt_pkg::DIR_UP, agt_pkg::DIR_LEFT);
		v = $urandom_range(0, 3);
		return (v == 0) ? DIR_NONE : v + agt_pkg::DIR_LEFT;
	endfunction

	// Default dimensions: empty cells, and loads and starts outside storage.
	task automatic test_reset_state();
		issue_command(agt_pkg::CMD_TRACE, 1, 1, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, 0, 5, agt_pkg::DIR_DOWN);
		issue_command(agt_pkg::CMD_LOAD, 5, 0, agt_pkg::DIR_DOWN);
		issue_command(agt_pkg::CMD_LOAD, GRID_MAX + 1, 3, agt_pkg::DIR_LEFT);
		issue_command(agt_pkg::CMD_LOAD, 255, 255, 7);
		issue_command(agt_pkg::CMD_TRACE, 0, 5, 7);
		issue_command(agt_pkg::CMD_TRACE, 255, 255, DIR_NONE);
		wait_idle();
	endtask

	// A 4x4 grid with one exit of each side, a loop, and starts beyond the grid.
	task automatic test_exit_sides();
		write_dims(4, 4);
		issue_command(agt_pkg::CMD_LOAD, 4, 2, agt_pkg::DIR_DOWN);
		issue_command(agt_pkg::CMD_TRACE, 4, 2, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, 1, 3, agt_pkg::DIR_UP);
		issue_command(agt_pkg::CMD_TRACE, 1, 3, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, 3, 1, agt_pkg::DIR_LEFT);
		issue_command(agt_pkg::CMD_TRACE, 3, 1, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, 3, 4, agt_pkg::DIR_RIGHT);
		issue_command(agt_pkg::CMD_TRACE, 3, 4, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, 1, 1, agt_pkg::DIR_RIGHT);
		issue_command(agt_pkg::CMD_LOAD, 1, 2, agt_pkg::DIR_DOWN);
		issue_command(agt_pkg::CMD_LOAD, 2, 2, agt_pkg::DIR_LEFT);
		issue_command(agt_pkg::CMD_LOAD, 2, 1, agt_pkg::DIR_UP);
		issue_command(agt_pkg::CMD_TRACE, 1, 1, DIR_NONE);
		issue_command(agt_pkg::CMD_TRACE, 2, 2, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, 6, 6, agt_pkg::DIR_LEFT);
		issue_command(agt_pkg::CMD_TRACE, 6, 6, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, 2, 6, agt_pkg::DIR_LEFT);
		issue_command(agt_pkg::CMD_TRACE, 2, 6, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, 2, 3, 7);
		issue_command(agt_pkg::CMD_TRACE, 2, 3, DIR_NONE);
		wait_idle();
	endtask

	// Zero rows puts every position outside; values above the store act as its size.
	task automatic test_dim_extremes();
		write_dims(0, 255);
		issue_command(agt_pkg::CMD_TRACE, 2, 2, DIR_NONE);
		wait_idle();
		write_dims(255, 255);
		issue_command(agt_pkg::CMD_LOAD, GRID_MAX, GRID_MAX, agt_pkg::DIR_DOWN);
		issue_command(agt_pkg::CMD_TRACE, GRID_MAX, GRID_MAX, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, GRID_MAX, GRID_MAX, agt_pkg::DIR_RIGHT);
		issue_command(agt_pkg::CMD_TRACE, GRID_MAX, GRID_MAX, DIR_NONE);
		issue_command(agt_pkg::CMD_LOAD, GRID_MAX, 1, agt_pkg::DIR_LEFT);
		issue_command(agt_pkg::CMD_TRACE, GRID_MAX, 1, DIR_NONE);
		wait_idle();
	endtask

	// Each phase picks dimensions, fills a window of the grid with random arrows,
	// then traces mostly from inside that window with some noise mixed in.
	task automatic test_random_phases();
		int rows_val;
		int cols_val;
		int lim_r;
		int lim_c;
		int win_h;
		int win_w;
		int r0;
		int c0;
		int n_traces;
		int sel;
		while (items_sent < ITEM_GOAL) begin
			rows_val = pick_dim();
			cols_val = pick_dim();
			wait_idle();
			write_dims(rows_val, cols_val);
			lim_r = (rows_val == 0 || rows_val > GRID_MAX) ? GRID_MAX : rows_val;
			lim_c = (cols_val == 0 || cols_val > GRID_MAX) ? GRID_MAX : cols_val;
			win_h = $urandom_range(1, (lim_r < 8) ? lim_r : 8);
			win_w = $urandom_range(1, (lim_c < 8) ? lim_c : 8);
			r0 = $urandom_range(1, lim_r - win_h + 1);
			c0 = $urandom_range(1, lim_c - win_w + 1);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int r = r0; r < r0 + win_h; r++)
				for (int c = c0; c < c0 + win_w; c++)
					issue_command(agt_pkg::CMD_LOAD, r, c, random_code());
			n_traces = $urandom_range(8, 24);
			repeat (n_traces) begin
				sel = $urandom_range(0, 9);
				if (sel < 7)
					issue_command(agt_pkg::CMD_TRACE, $urandom_range(r0, r0 + win_h - 1),
						$urandom_range(c0, c0 + win_w - 1), $urandom_range(0, 7));
				else if (sel < 8)
					issue_command(agt_pkg::CMD_LOAD, $urandom_range(r0, r0 + win_h - 1),
						$urandom_range(c0, c0 + win_w - 1), random_code());
				else
					issue_command(1'($urandom_range(0, 1)), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 7));
			end
		end
		no_gaps = 1'b0;
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= agt_pkg::CMD_LOAD;
		row <= '0;
		col <= '0;
		direction <= DIR_NONE;
		cfg_wr_en <= 1'b0;
		cfg_addr <= agt_pkg::REG_NUM_ROWS;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_exit_sides();
		test_dim_extremes();
		test_random_phases();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_exits.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/agt_pkg.sv
hw/rtl/agt_ctrl.sv
hw/rtl/agt_datapath.sv
hw/rtl/arrow_grid_exit_tracer.sv
hw/rtl/agt_checker.sv
sim/testbench.sv
